@@ hw/rtl/cpcm_pkg.sv @@
// shared types, formats and register codes of the cut plane coordinate mapper
package cpcm_pkg;

  localparam int DIM_BITS       = 11;
  localparam int AXIS_FRAC_BITS = 14;

  localparam int COORD_W = 12;
  localparam int SLAB_W  = 20;
  localparam int ORG_W   = 20;
  localparam int UNIT_W  = 16;

  // Q16 point times a unit vector gives this many fraction bits
  localparam int SHIFT_Q = 16 + AXIS_FRAC_BITS;

  // centred point before scaling: a*256 - dim*128 - origin
  localparam int UW = ((DIM_BITS + 7 > ORG_W) ? DIM_BITS + 7 : ORG_W) + 2;

  // 0.49 in the final fixed-point format
  localparam logic signed [63:0] RND_K = 64'sd32113 <<< AXIS_FRAC_BITS;

  // register stages from accept to result
  localparam int LAT = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN  = 3'd0,
    REG_X_AXIS  = 3'd1,
    REG_Y_AXIS  = 3'd2,
    REG_NORMAL  = 3'd3,
    REG_VOL_DIM = 3'd4,
    REG_SQUEEZE = 3'd5,
    REG_IMG_DIM = 3'd6
  } cfg_reg_e;

  localparam logic [3*ORG_W-1:0]    ORIGIN_RST  = '0;
  localparam logic [3*UNIT_W-1:0]   X_AXIS_RST  = 48'd16384;
  localparam logic [3*UNIT_W-1:0]   Y_AXIS_RST  = 48'd16384 << 16;
  localparam logic [3*UNIT_W-1:0]   NORMAL_RST  = 48'd16384 << 32;
  localparam logic [3*DIM_BITS-1:0] VOL_DIM_RST = '0;
  localparam logic [31:0]           SQUEEZE_RST = 32'h0100_0100;
  localparam logic [2*DIM_BITS-1:0] IMG_DIM_RST = '0;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
    logic signed [COORD_W-1:0] coord_c;
    logic [SLAB_W-1:0]         slab_limit;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] res_a;
    logic signed [COORD_W-1:0] res_b;
    logic signed [COORD_W-1:0] res_c;
    logic                      out_of_range;
  } res_t;

  typedef struct packed {
    logic [2:0][ORG_W-1:0]    org;
    logic [2:0][UNIT_W-1:0]   ax;
    logic [2:0][UNIT_W-1:0]   ay;
    logic [2:0][UNIT_W-1:0]   an;
    logic [2:0][DIM_BITS-1:0] vd;
    logic [15:0]              sq;
    logic [15:0]              rc;
    logic [DIM_BITS-1:0]      imw;
    logic [DIM_BITS-1:0]      imh;
  } cfg_t;

endpackage

@@ hw/rtl/cpcm_cfg.sv @@
// configuration registers and their decoded plane set-up
module cpcm_cfg import cpcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [3*ORG_W-1:0]    origin;
  logic [3*UNIT_W-1:0]   x_axis;
  logic [3*UNIT_W-1:0]   y_axis;
  logic [3*UNIT_W-1:0]   normal;
  logic [3*DIM_BITS-1:0] vol_dims;
  logic [31:0]           squeeze;
  logic [2*DIM_BITS-1:0] img_dims;
  logic                  wr;

  assign cfg_ready = ~rst;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin   <= ORIGIN_RST;
      x_axis   <= X_AXIS_RST;
      y_axis   <= Y_AXIS_RST;
      normal   <= NORMAL_RST;
      vol_dims <= VOL_DIM_RST;
      squeeze  <= SQUEEZE_RST;
      img_dims <= IMG_DIM_RST;
    end else if (wr) begin
      unique case (cfg_index)
        REG_ORIGIN:  origin   <= cfg_data[3*ORG_W-1:0];
        REG_X_AXIS:  x_axis   <= cfg_data[3*UNIT_W-1:0];
        REG_Y_AXIS:  y_axis   <= cfg_data[3*UNIT_W-1:0];
        REG_NORMAL:  normal   <= cfg_data[3*UNIT_W-1:0];
        REG_VOL_DIM: vol_dims <= cfg_data[3*DIM_BITS-1:0];
        REG_SQUEEZE: squeeze  <= cfg_data[31:0];
        REG_IMG_DIM: img_dims <= cfg_data[2*DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg.org[i] = origin[ORG_W*i +: ORG_W];
      cfg.ax[i]  = x_axis[UNIT_W*i +: UNIT_W];
      cfg.ay[i]  = y_axis[UNIT_W*i +: UNIT_W];
      cfg.an[i]  = normal[UNIT_W*i +: UNIT_W];
      cfg.vd[i]  = vol_dims[DIM_BITS*i +: DIM_BITS];
    end
    cfg.sq  = squeeze[15:0];
    cfg.rc  = squeeze[31:16];
    cfg.imw = img_dims[DIM_BITS-1:0];
    cfg.imh = img_dims[2*DIM_BITS-1:DIM_BITS];
  end

  a_squeeze_wr: assert property (@(posedge clk) disable iff (rst)
    wr && cfg_index == REG_SQUEEZE |=>
      cfg.sq == $past(cfg_data[15:0]) && cfg.rc == $past(cfg_data[31:16]))
    else $error("squeeze write not taken");

  a_normal_wr: assert property (@(posedge clk) disable iff (rst)
    wr && cfg_index == REG_NORMAL |=> cfg.an[2] == $past(cfg_data[47:32]))
    else $error("normal write not taken");

  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    !wr |=> $stable(cfg))
    else $error("configuration changed without a write");

endmodule

@@ hw/rtl/cpcm_fwd.sv @@
// voxel to plane datapath: five stages from request to flagged result
module cpcm_fwd import cpcm_pkg::*; (
  input  logic clk,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);

  localparam int TW = UW + 18;
  localparam int MW = UW + 17;
  localparam int NW = TW + 17;
  localparam int CW = TW + 18;
  localparam int QW = CW - SHIFT_Q;

  localparam logic signed [QW-1:0] DMAX = QW'($signed(12'h7ff));
  localparam logic signed [QW-1:0] DMIN = QW'($signed(12'h800));

  // stage 1: centred point
  logic signed [UW-1:0] u0_1, u1_1, w2_1;
  logic [SLAB_W-1:0]    slab1;
  // stage 2: squeezed z
  logic signed [UW-1:0] u0_2, u1_2;
  logic signed [TW-1:0] t2_2;
  logic [SLAB_W-1:0]    slab2;
  // stage 3: products with normal and axes
  logic signed [MW-1:0] pn0, pn1, px0, px1, py0, py1;
  logic signed [NW-1:0] pn2, px2, py2;
  logic [SLAB_W-1:0]    slab3;
  // stage 4: dot products with offsets and rounding
  logic signed [CW-1:0] cd4, vc4, vx4, vy4;
  logic [SLAB_W-1:0]    slab4;

  logic signed [CW-1:0] offx, offy, rnd_c;
  res_t                 res_next;

  assign rnd_c = CW'(RND_K);
  assign offx  = (CW'($signed({1'b0, cfg.imw})) <<< (SHIFT_Q - 1)) + rnd_c;
  assign offy  = (CW'($signed({1'b0, cfg.imh})) <<< (SHIFT_Q - 1)) + rnd_c;

  always_ff @(posedge clk) begin
    u0_1  <= (UW'(req.coord_a) <<< 8) - (UW'($signed({1'b0, cfg.vd[0]})) <<< 7)
             - UW'($signed(cfg.org[0]));
    u1_1  <= (UW'(req.coord_b) <<< 8) - (UW'($signed({1'b0, cfg.vd[1]})) <<< 7)
             - UW'($signed(cfg.org[1]));
    w2_1  <= (UW'(req.coord_c) <<< 8) - (UW'($signed({1'b0, cfg.vd[2]})) <<< 7);
    slab1 <= req.slab_limit;

    u0_2  <= u0_1;
    u1_2  <= u1_1;
    t2_2  <= TW'(w2_1) * TW'($signed({1'b0, cfg.sq}))
             - (TW'($signed(cfg.org[2])) <<< 8);
    slab2 <= slab1;

    pn0   <= MW'(u0_2) * MW'($signed(cfg.an[0]));
    pn1   <= MW'(u1_2) * MW'($signed(cfg.an[1]));
    pn2   <= NW'(t2_2) * NW'($signed(cfg.an[2]));
    px0   <= MW'(u0_2) * MW'($signed(cfg.ax[0]));
    px1   <= MW'(u1_2) * MW'($signed(cfg.ax[1]));
    px2   <= NW'(t2_2) * NW'($signed(cfg.ax[2]));
    py0   <= MW'(u0_2) * MW'($signed(cfg.ay[0]));
    py1   <= MW'(u1_2) * MW'($signed(cfg.ay[1]));
    py2   <= NW'(t2_2) * NW'($signed(cfg.ay[2]));
    slab3 <= slab2;

    // x and y products carry Q8 points, so they move up by 8 bits
    cd4   <= ((CW'(pn0) + CW'(pn1)) <<< 8) + CW'(pn2);
    vc4   <= ((CW'(pn0) + CW'(pn1)) <<< 8) + CW'(pn2) + rnd_c;
    vx4   <= ((CW'(px0) + CW'(px1)) <<< 8) + CW'(px2) + offx;
    vy4   <= ((CW'(py0) + CW'(py1)) <<< 8) + CW'(py2) + offy;
    slab4 <= slab3;

    res   <= res_next;
  end

  // stage 5: slab test, truncation toward zero, saturation of the distance, image test
  always_comb begin
    logic signed [CW-1:0] lim;
    logic                 slab_ok, x_ok, y_ok, c_frac;
    logic [QW-1:0]        qx, qy;
    logic signed [QW-1:0] qc, tz, oc;

    lim     = CW'($signed({1'b0, slab4})) <<< (8 + AXIS_FRAC_BITS);
    slab_ok = (cd4 <= lim) && (cd4 >= -lim);

    // a negative value truncates to zero only when its floor is -1 and it has a fraction
    qx   = vx4[CW-1:SHIFT_Q];
    qy   = vy4[CW-1:SHIFT_Q];
    x_ok = vx4[CW-1] ? ((&qx) && (|vx4[SHIFT_Q-1:0]) && (cfg.imw != '0))
                     : (qx < QW'(cfg.imw));
    y_ok = vy4[CW-1] ? ((&qy) && (|vy4[SHIFT_Q-1:0]) && (cfg.imh != '0))
                     : (qy < QW'(cfg.imh));

    qc     = $signed(vc4[CW-1:SHIFT_Q]);
    c_frac = vc4[CW-1] && (|vc4[SHIFT_Q-1:0]);
    tz     = qc + $signed(QW'(c_frac));
    if (tz > DMAX) begin
      oc = DMAX;
    end else if (tz < DMIN) begin
      oc = DMIN;
    end else begin
      oc = tz;
    end

    res_next = '0;
    if (slab_ok && x_ok && y_ok) begin
      res_next.res_a = vx4[CW-1] ? '0 : qx[COORD_W-1:0];
      res_next.res_b = vy4[CW-1] ? '0 : qy[COORD_W-1:0];
      res_next.res_c = oc[COORD_W-1:0];
    end else begin
      res_next.out_of_range = 1'b1;
    end
  end

endmodule

@@ hw/rtl/cpcm_inv.sv @@
// plane to voxel datapath: five stages from request to bounds-checked result
module cpcm_inv import cpcm_pkg::*; (
  input  logic clk,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);

  localparam int MW = UW + 17;
  localparam int PW = ((MW > ORG_W + AXIS_FRAC_BITS) ? MW : ORG_W + AXIS_FRAC_BITS) + 2;
  localparam int RW = PW + 17;
  localparam int VW = ((RW > DIM_BITS + SHIFT_Q) ? RW : DIM_BITS + SHIFT_Q) + 2;
  localparam int QW = VW - SHIFT_Q;

  // stage 1: pixel centred on the image
  logic signed [UW-1:0] x1, y1;
  // stage 2: axis products
  logic signed [MW-1:0] mx [3];
  logic signed [MW-1:0] my [3];
  // stage 3: point in volume space
  logic signed [PW-1:0] sp [3];
  // stage 4: scaled and offset
  logic signed [VW-1:0] v0_4, v1_4;
  logic signed [RW-1:0] m2_4;

  logic signed [VW-1:0] off [3];
  res_t                 res_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = (VW'($signed({1'b0, cfg.vd[i]})) <<< (SHIFT_Q - 1)) + VW'(RND_K);
    end
  end

  always_ff @(posedge clk) begin
    x1 <= (UW'(req.coord_a) <<< 8) - (UW'($signed({1'b0, cfg.imw})) <<< 7);
    y1 <= (UW'(req.coord_b) <<< 8) - (UW'($signed({1'b0, cfg.imh})) <<< 7);

    for (int i = 0; i < 3; i++) begin
      mx[i] <= MW'(x1) * MW'($signed(cfg.ax[i]));
      my[i] <= MW'(y1) * MW'($signed(cfg.ay[i]));
      sp[i] <= (PW'($signed(cfg.org[i])) <<< AXIS_FRAC_BITS) + PW'(mx[i]) + PW'(my[i]);
    end

    // x and y move up to the final format, z goes through the reciprocal
    v0_4 <= (VW'(sp[0]) <<< 8) + off[0];
    v1_4 <= (VW'(sp[1]) <<< 8) + off[1];
    m2_4 <= RW'(sp[2]) * RW'($signed({1'b0, cfg.rc}));

    res <= res_next;
  end

  // stage 5: truncation toward zero and volume bounds
  always_comb begin
    logic signed [VW-1:0] v2;
    logic [QW-1:0]        q0, q1, q2;
    logic                 ok0, ok1, ok2;

    v2  = VW'(m2_4) + off[2];
    q0  = v0_4[VW-1:SHIFT_Q];
    q1  = v1_4[VW-1:SHIFT_Q];
    q2  = v2[VW-1:SHIFT_Q];
    // a negative value truncates to zero only when its floor is -1 and it has a fraction
    ok0 = v0_4[VW-1] ? ((&q0) && (|v0_4[SHIFT_Q-1:0]) && (cfg.vd[0] != '0))
                     : (q0 < QW'(cfg.vd[0]));
    ok1 = v1_4[VW-1] ? ((&q1) && (|v1_4[SHIFT_Q-1:0]) && (cfg.vd[1] != '0))
                     : (q1 < QW'(cfg.vd[1]));
    ok2 = v2[VW-1]   ? ((&q2) && (|v2[SHIFT_Q-1:0]) && (cfg.vd[2] != '0))
                     : (q2 < QW'(cfg.vd[2]));

    res_next = '0;
    if (ok0 && ok1 && ok2) begin
      res_next.res_a = v0_4[VW-1] ? '0 : q0[COORD_W-1:0];
      res_next.res_b = v1_4[VW-1] ? '0 : q1[COORD_W-1:0];
      res_next.res_c = v2[VW-1]   ? '0 : q2[COORD_W-1:0];
    end else begin
      res_next.out_of_range = 1'b1;
    end
  end

endmodule

@@ hw/rtl/cut_plane_coordinate_mapper_core.sv @@
// top level of the cut plane coordinate mapper
// Maps voxels onto an oblique cut plane (req_type 0) and cut image pixels
// back into the volume (req_type 1).
// Request channel: a request is taken at each rising edge with start high
// and busy low. busy is low whenever the block is out of reset, so a new
// request can be issued in every cycle.
// Result channel: res_valid strobes for one cycle with res once the request
// has passed the datapath stages, in request order. One result per
// request; the receiver cannot hold results off and none is needed.
// Throughput is one request per cycle, set by the five-stage datapaths that
// run side by side (forward: centring, squeeze multiply, dot-product
// multipliers, adder trees with rounding offset, truncation and bounds test).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while no request is in flight. Registers take effect on the next
// request.
// Reset (rst, synchronous) restores the register defaults and drops any
// request in flight; busy is held high and cfg_ready low while rst is high.
module cut_plane_coordinate_mapper_core import cpcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  res_valid,
  output res_t                  res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t           cfg;
  res_t           fwd_res, inv_res;
  logic           accept;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] typ;

  assign busy   = rst;
  assign accept = start & ~busy;

  cpcm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpcm_fwd u_fwd (
    .clk (clk),
    .req (req),
    .cfg (cfg),
    .res (fwd_res)
  );

  cpcm_inv u_inv (
    .clk (clk),
    .req (req),
    .cfg (cfg),
    .res (inv_res)
  );

  // valid and request type travel alongside the datapath stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
    typ <= {typ[LAT-2:0], req.req_type};
  end

  assign res_valid = vld[LAT-1];
  assign res       = typ[LAT-1] ? inv_res : fwd_res;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT res_valid)
    else $error("result missing after a request");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_of_range |->
      res.res_a == '0 && res.res_b == '0 && res.res_c == '0)
    else $error("flagged result carries coordinates");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result strobe straight after reset");

endmodule

@@ verif/cut_plane_coordinate_mapper_core_tb.sv @@
// self-checking testbench of the cut plane coordinate mapper core
module cut_plane_coordinate_mapper_core_tb;
  import cpcm_pkg::*;

  localparam logic   REQ_TO_PLANE  = 1'b0;
  localparam logic   REQ_TO_VOLUME = 1'b1;
  localparam int     FRAC_SHIFT    = 16 + AXIS_FRAC_BITS;
  localparam longint ROUND_OFFSET  = longint'(32113) <<< AXIS_FRAC_BITS;
  localparam longint COORD_MAX     = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN     = -(longint'(1) <<< (COORD_W - 1));
  localparam int     SLAB_MAX      = (1 << SLAB_W) - 1;
  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     PHASE_ITEMS   = 95;

  typedef enum int {SETUP_ONES, SETUP_ZEROS, SETUP_RAW, SETUP_PLANE} setup_e;

  class map_scoreboard;
    res_t waiting[$];
    int errors = 0;

    function void note(res_t r);
      waiting.push_back(r);
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function void report(string field, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      errors++;
    endfunction

    function void check(res_t got);
      res_t want;
      if (waiting.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = waiting.pop_front();
      if (got.res_a !== want.res_a) report("res_a", want.res_a, got.res_a);
      if (got.res_b !== want.res_b) report("res_b", want.res_b, got.res_b);
      if (got.res_c !== want.res_c) report("res_c", want.res_c, got.res_c);
      if (got.out_of_range !== want.out_of_range)
        report("out_of_range", want.out_of_range, got.out_of_range);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  res_valid;
  res_t                  res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register copies used for prediction
  logic [59:0]           origin_reg = '0;
  logic [47:0]           xaxis_reg  = 48'd16384;
  logic [47:0]           yaxis_reg  = 48'd16384 << 16;
  logic [47:0]           normal_reg = 48'd16384 << 32;
  logic [3*DIM_BITS-1:0] vdim_reg   = '0;
  logic [31:0]           sqz_reg    = 32'h0100_0100;
  logic [2*DIM_BITS-1:0] idim_reg   = '0;

  map_scoreboard maps;
  int            cycle_count = 0;
  int            plane_extent = 1;

  cut_plane_coordinate_mapper_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid) maps.check(res);
  end

  // truncating shift toward zero
  function automatic longint shift_to_zero(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic res_t map_point(req_t r);
    longint a, b, c, imw, imh, sq, rc, half;
    longint org[3], ux[3], uy[3], un[3], vd[3], t[3], sp[3], s[3];
    longint plane_dist, mag, lim, px, py, ox, oy, oc, x1, y1;
    res_t p;
    a = longint'($signed(r.coord_a));
    b = longint'($signed(r.coord_b));
    c = longint'($signed(r.coord_c));
    for (int i = 0; i < 3; i++) begin
      org[i] = longint'($signed(origin_reg[20*i +: 20]));
      ux[i]  = longint'($signed(xaxis_reg[16*i +: 16]));
      uy[i]  = longint'($signed(yaxis_reg[16*i +: 16]));
      un[i]  = longint'($signed(normal_reg[16*i +: 16]));
      vd[i]  = longint'(vdim_reg[DIM_BITS*i +: DIM_BITS]);
    end
    imw  = longint'(idim_reg[DIM_BITS-1:0]);
    imh  = longint'(idim_reg[2*DIM_BITS-1:DIM_BITS]);
    sq   = longint'(sqz_reg[15:0]);
    rc   = longint'(sqz_reg[31:16]);
    half = longint'(1) <<< (FRAC_SHIFT - 1);
    p = '0;
    p.out_of_range = 1'b1;
    if (r.req_type == REQ_TO_PLANE) begin
      t[0] = ((a * 256 - vd[0] * 128) - org[0]) * 256;
      t[1] = ((b * 256 - vd[1] * 128) - org[1]) * 256;
      t[2] = (c * 256 - vd[2] * 128) * sq - org[2] * 256;
      plane_dist = t[0] * un[0] + t[1] * un[1] + t[2] * un[2];
      lim  = longint'(r.slab_limit) <<< (8 + AXIS_FRAC_BITS);
      mag  = (plane_dist < 0) ? -plane_dist : plane_dist;
      if (mag <= lim) begin
        px = t[0] * ux[0] + t[1] * ux[1] + t[2] * ux[2];
        py = t[0] * uy[0] + t[1] * uy[1] + t[2] * uy[2];
        ox = shift_to_zero(px + imw * half + ROUND_OFFSET, FRAC_SHIFT);
        oy = shift_to_zero(py + imh * half + ROUND_OFFSET, FRAC_SHIFT);
        oc = shift_to_zero(plane_dist + ROUND_OFFSET, FRAC_SHIFT);
        if (ox >= 0 && ox < imw && oy >= 0 && oy < imh) begin
          if (oc > COORD_MAX) oc = COORD_MAX;
          if (oc < COORD_MIN) oc = COORD_MIN;
          p.res_a = ox[COORD_W-1:0];
          p.res_b = oy[COORD_W-1:0];
          p.res_c = oc[COORD_W-1:0];
          p.out_of_range = 1'b0;
        end
      end
    end else begin
      x1 = a * 256 - imw * 128;
      y1 = b * 256 - imh * 128;
      for (int i = 0; i < 3; i++)
        sp[i] = (org[i] <<< AXIS_FRAC_BITS) + y1 * uy[i] + x1 * ux[i];
      s[0] = shift_to_zero(sp[0] * 256 + vd[0] * half + ROUND_OFFSET, FRAC_SHIFT);
      s[1] = shift_to_zero(sp[1] * 256 + vd[1] * half + ROUND_OFFSET, FRAC_SHIFT);
      s[2] = shift_to_zero(sp[2] * rc + vd[2] * half + ROUND_OFFSET, FRAC_SHIFT);
      if (s[0] >= 0 && s[0] < vd[0] && s[1] >= 0 && s[1] < vd[1] &&
          s[2] >= 0 && s[2] < vd[2]) begin
        p.res_a = s[0][COORD_W-1:0];
        p.res_b = s[1][COORD_W-1:0];
        p.res_c = s[2][COORD_W-1:0];
        p.out_of_range = 1'b0;
      end
    end
    return p;
  endfunction

  function automatic req_t make_request(logic kind, int a, int b, int c, int slab);
    req_t r;
    r.req_type   = kind;
    r.coord_a    = a[COORD_W-1:0];
    r.coord_b    = b[COORD_W-1:0];
    r.coord_c    = c[COORD_W-1:0];
    r.slab_limit = slab[SLAB_W-1:0];
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] pick_in(logic [DIM_BITS-1:0] dim);
    if (dim == 0) return COORD_W'($urandom_range(0, 3));
    return COORD_W'($urandom_range(0, dim - 1));
  endfunction

  function automatic req_t pick_request(bit aimed);
    req_t r;
    int   cap;
    r.req_type   = 1'($urandom_range(0, 1));
    r.coord_a    = COORD_W'($urandom);
    r.coord_b    = COORD_W'($urandom);
    r.coord_c    = COORD_W'($urandom);
    r.slab_limit = SLAB_W'($urandom);
    if (aimed) begin
      if (r.req_type == REQ_TO_PLANE) begin
        r.coord_a = pick_in(vdim_reg[DIM_BITS-1:0]);
        r.coord_b = pick_in(vdim_reg[2*DIM_BITS-1:DIM_BITS]);
        r.coord_c = pick_in(vdim_reg[3*DIM_BITS-1:2*DIM_BITS]);
        cap = (plane_extent * 256 > SLAB_MAX) ? SLAB_MAX : plane_extent * 256;
        if ($urandom_range(0, 1)) r.slab_limit = SLAB_W'($urandom_range(0, cap));
        else r.slab_limit = SLAB_W'($urandom_range(0, 1023));
      end else begin
        r.coord_a = pick_in(idim_reg[DIM_BITS-1:0]);
        r.coord_b = pick_in(idim_reg[2*DIM_BITS-1:DIM_BITS]);
      end
    end
    return r;
  endfunction

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  function automatic logic [15:0] to_unit(real v);
    int k;
    k = $rtoi(v * 16384.0 + ((v < 0.0) ? -0.5 : 0.5));
    return k[15:0];
  endfunction

  task automatic send_request(req_t r, int gap);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    maps.note(map_point(r));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    logic [63:0] data;
    int          w;
    case (idx)
      REG_ORIGIN:                         w = 3 * ORG_W;
      REG_X_AXIS, REG_Y_AXIS, REG_NORMAL: w = 3 * UNIT_W;
      REG_VOL_DIM:                        w = 3 * DIM_BITS;
      REG_SQUEEZE:                        w = 32;
      default:                            w = 2 * DIM_BITS;
    endcase
    data = value & ((64'd1 << w) - 64'd1);
    // unused upper bits carry junk now and then
    if ($urandom_range(0, 1)) data = data | ({$urandom, $urandom} << w);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORIGIN:  origin_reg = data[59:0];
      REG_X_AXIS:  xaxis_reg  = data[47:0];
      REG_Y_AXIS:  yaxis_reg  = data[47:0];
      REG_NORMAL:  normal_reg = data[47:0];
      REG_VOL_DIM: vdim_reg   = data[3*DIM_BITS-1:0];
      REG_SQUEEZE: sqz_reg    = data[31:0];
      default:     idim_reg   = data[2*DIM_BITS-1:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [63:0] value, bit scramble);
    for (int k = REG_ORIGIN; k <= REG_IMG_DIM; k++)
      write_reg(cfg_reg_e'(k), scramble ? {$urandom, $urandom} : value);
  endtask

  task automatic wait_drained();
    while (maps.pending() != 0) @(posedge clk);
    repeat (LAT + 3) @(posedge clk);
  endtask

  // random rotation of the plane, volume and image sized around it
  task automatic setup_plane();
    real         pi_v, ang, cs[3], sn[3], m[3][3];
    int          vd[3], ext, iw, ih, sqv, rcv, span, comp;
    logic [59:0] org;
    pi_v = 3.14159265358979;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 1)) ang = $urandom_range(0, 3) * pi_v / 2.0;
      else ang = $urandom_range(0, 3599) * pi_v / 1800.0;
      cs[k] = $cos(ang);
      sn[k] = $sin(ang);
    end
    m[0][0] = cs[0] * cs[1];
    m[0][1] = cs[0] * sn[1] * sn[2] - sn[0] * cs[2];
    m[0][2] = cs[0] * sn[1] * cs[2] + sn[0] * sn[2];
    m[1][0] = sn[0] * cs[1];
    m[1][1] = sn[0] * sn[1] * sn[2] + cs[0] * cs[2];
    m[1][2] = sn[0] * sn[1] * cs[2] - cs[0] * sn[2];
    m[2][0] = -sn[1];
    m[2][1] = cs[1] * sn[2];
    m[2][2] = cs[1] * cs[2];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 19))
        0:       vd[k] = 0;
        1, 2, 3: vd[k] = $urandom_range(1, 2047);
        default: vd[k] = $urandom_range(1, 96);
      endcase
    end
    sqv = $urandom_range(128, 1024);
    rcv = (65536 + sqv / 2) / sqv;
    if ($urandom_range(0, 9) == 0) rcv = $urandom_range(0, 65535);
    ext = vd[0] + vd[1] + (vd[2] * sqv) / 256 + 1;
    iw = $urandom_range(ext / 2, ext);
    ih = $urandom_range(ext / 2, ext);
    if (iw > 2047) iw = 2047;
    if (ih > 2047) ih = 2047;
    if (iw < 1) iw = 1;
    if (ih < 1) ih = 1;
    span = ext * 64;
    if (span > (1 << 18)) span = 1 << 18;
    for (int k = 0; k < 3; k++) begin
      comp = $urandom_range(0, span) - span / 2;
      org[20*k +: 20] = comp[19:0];
    end
    plane_extent = ext;
    write_reg(REG_ORIGIN, {4'h0, org});
    write_reg(REG_X_AXIS, {16'h0, to_unit(m[2][0]), to_unit(m[1][0]), to_unit(m[0][0])});
    write_reg(REG_Y_AXIS, {16'h0, to_unit(m[2][1]), to_unit(m[1][1]), to_unit(m[0][1])});
    write_reg(REG_NORMAL, {16'h0, to_unit(m[2][2]), to_unit(m[1][2]), to_unit(m[0][2])});
    write_reg(REG_VOL_DIM, {31'h0, vd[2][10:0], vd[1][10:0], vd[0][10:0]});
    write_reg(REG_SQUEEZE, {32'h0, rcv[15:0], sqv[15:0]});
    write_reg(REG_IMG_DIM, {42'h0, ih[10:0], iw[10:0]});
  endtask

  task automatic directed_requests();
    int mode;
    mode = 2;
    // reset settings: empty volume and image flag everything
    send_request(make_request(REQ_TO_PLANE, 0, 0, 0, 0), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, 0, 0, 0, 0), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, 2047, 2047, 2047, SLAB_MAX), draw_gap(mode));
    start <= 1'b0;
    wait_drained();
    // axis-aligned plane through the middle of a 64x64x32 volume
    write_reg(REG_ORIGIN, 64'd0);
    write_reg(REG_X_AXIS, 64'd16384);
    write_reg(REG_Y_AXIS, 64'd16384 << 16);
    write_reg(REG_NORMAL, 64'd16384 << 32);
    write_reg(REG_VOL_DIM, {31'h0, 11'd32, 11'd64, 11'd64});
    write_reg(REG_SQUEEZE, 64'h0100_0100);
    write_reg(REG_IMG_DIM, {42'h0, 11'd64, 11'd64});
    send_request(make_request(REQ_TO_PLANE, 32, 32, 16, 0), draw_gap(mode));
    // distance exactly on the slab limit passes, one below fails
    send_request(make_request(REQ_TO_PLANE, 32, 32, 20, 1024), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, 32, 32, 20, 1023), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, -2048, -2048, -2048, SLAB_MAX), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, 2047, 2047, 2047, SLAB_MAX), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, 0, 0, 0, SLAB_MAX), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, 32, 32, 0, 0), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, 0, 0, -2048, SLAB_MAX), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, 63, 63, 2047, 0), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, -2048, -2048, 0, 0), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, 2047, 2047, 0, 0), draw_gap(mode));
    start <= 1'b0;
    wait_drained();
    // fractional origin gives a slightly negative image x that truncates to 0,
    // squeeze of 8 drives the distance into saturation
    write_reg(REG_ORIGIN, 64'd202);
    write_reg(REG_SQUEEZE, 64'h0020_0800);
    send_request(make_request(REQ_TO_PLANE, 0, 32, 16, SLAB_MAX), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, 32, 32, 2047, SLAB_MAX), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, 32, 32, -2048, SLAB_MAX), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, 32, 32, 0, 0), draw_gap(mode));
    send_request(make_request(REQ_TO_VOLUME, 10, 50, 0, 0), draw_gap(mode));
    start <= 1'b0;
    wait_drained();
    // zero depth and zero squeeze and reciprocal
    write_reg(REG_VOL_DIM, {31'h0, 11'd0, 11'd64, 11'd64});
    write_reg(REG_SQUEEZE, 64'd0);
    send_request(make_request(REQ_TO_VOLUME, 32, 32, 0, 0), draw_gap(mode));
    send_request(make_request(REQ_TO_PLANE, 32, 32, 5, 0), draw_gap(mode));
    start <= 1'b0;
  endtask

  task automatic run_phase(setup_e kind, int n);
    int mode;
    bit aimed;
    wait_drained();
    case (kind)
      SETUP_ONES:  write_all('1, 1'b0);
      SETUP_ZEROS: write_all('0, 1'b0);
      SETUP_RAW:   write_all('0, 1'b1);
      default:     setup_plane();
    endcase
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      // most requests on a usable plane stay inside the volume or image
      aimed = (kind == SETUP_PLANE) && ($urandom_range(0, 9) < 8);
      send_request(pick_request(aimed), draw_gap(mode));
    end
    start <= 1'b0;
  endtask

  initial begin
    maps = new;
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ORIGIN;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_requests();
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       run_phase(SETUP_ONES, PHASE_ITEMS);
        1:       run_phase(SETUP_ZEROS, PHASE_ITEMS);
        2, 9:    run_phase(SETUP_RAW, PHASE_ITEMS);
        default: run_phase(SETUP_PLANE, PHASE_ITEMS);
      endcase
    end
    wait_drained();
    if (maps.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cpcm_pkg.sv
hw/rtl/cpcm_cfg.sv
hw/rtl/cpcm_fwd.sv
hw/rtl/cpcm_inv.sv
hw/rtl/cut_plane_coordinate_mapper_core.sv
verif/cut_plane_coordinate_mapper_core_tb.sv
